// ===== hdl/scr_pkg.sv =====
// Shared types and constants for the sphere collision resolver.
// No dependencies; used by sphere_collision_resolver and its testbench.
`timescale 1ns / 1ps
`default_nettype none

package scr_pkg;

    localparam int MAX_BODIES_DEF = 8;
    localparam int POS_W          = 32;
    localparam int RAD_W          = 31;
    localparam int CFG_W          = 4;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_PASS   = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        K_ADDED   = 3'd0,
        K_FULL    = 3'd1,
        K_REMOVED = 3'd2,
        K_EMPTY   = 3'd3,
        K_HIT     = 3'd4,
        K_DONE    = 3'd5,
        K_READ    = 3'd6
    } t_kind;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_WAIT,
        S_EMIT,
        S_I_SCAN,
        S_I_WAIT,
        S_J_SCAN,
        S_J_WAIT,
        S_J_INC,
        S_MUL,
        S_CMP,
        S_SQRT,
        S_PMUL,
        S_PDIV,
        S_DIV,
        S_WB_B,
        S_WB_A
    } t_state;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [RAD_W-1:0]        radius;
        logic                    enabled;
        logic                    resolves;
    } t_body;

    // Upper bound on one push component (2^40), as 41 bits.
    localparam logic [40:0] PUSH_MAX = 41'h100_0000_0000;

endpackage

`default_nettype wire

// ===== hdl/scr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module scr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/scr_sqrt.sv =====
// Iterative integer square root of a 64-bit value, one bit pair per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module scr_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_val,
    output logic             o_done,
    output logic [31:0]      o_root
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [63:0] r_v, n_v;
    logic [63:0] r_r, n_r;
    logic [63:0] r_bit, n_bit;
    logic [63:0] trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_v    = r_v;
        n_r    = r_r;
        n_bit  = r_bit;
        trial  = r_r + r_bit;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_v    = i_val;
            n_r    = '0;
            n_bit  = 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (r_v >= trial) begin
                n_v = r_v - trial;
                n_r = (r_r >> 1) + r_bit;
            end else begin
                n_r = r_r >> 1;
            end
            n_bit = r_bit >> 2;
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_v   <= n_v;
        r_r   <= n_r;
        r_bit <= n_bit;
    end

    assign o_done = r_done;
    assign o_root = r_r[31:0];

endmodule

`default_nettype wire

// ===== hdl/scr_div.sv =====
// Restoring divider, 64-bit dividend by 33-bit divisor, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module scr_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [32:0] i_den,
    output logic             o_done,
    output logic [63:0]      o_quo
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_num, n_num;
    logic [63:0] r_quo, n_quo;
    logic [32:0] r_den, n_den;
    logic [32:0] r_rem, n_rem;
    logic [33:0] trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_quo  = r_quo;
        n_den  = r_den;
        n_rem  = r_rem;
        trial  = {r_rem, r_num[63]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_num  = i_num;
            n_den  = i_den;
            n_rem  = '0;
            n_quo  = '0;
        end else if (r_busy) begin
            n_num = {r_num[62:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                n_rem = 33'(trial - {1'b0, r_den});
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = trial[32:0];
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_num <= n_num;
        r_quo <= n_quo;
        r_den <= n_den;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// ===== hdl/sphere_collision_resolver.sv =====
// A pass tests every ordered pair of enabled bodies in the searched slots; a pushed pair
// takes a square root, then three divides, one per axis.
// One command at a time; a new beat is taken once the previous command's results are
// all queued. Reset clears the presence flags and sets the slot count r_slots to MAX_BODIES.
// Depends on scr_pkg, scr_ram, scr_sqrt, scr_div.
`timescale 1ns / 1ps
`default_nettype none

module sphere_collision_resolver #(
    parameter int MAX_BODIES = scr_pkg::MAX_BODIES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [scr_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [1:0]                      i_cmd,
    input  wire logic [2:0]                      i_slot,
    input  wire logic signed [scr_pkg::POS_W-1:0] i_pos_x,
    input  wire logic signed [scr_pkg::POS_W-1:0] i_pos_y,
    input  wire logic signed [scr_pkg::POS_W-1:0] i_pos_z,
    input  wire logic [scr_pkg::RAD_W-1:0]       i_radius,
    input  wire logic                            i_enabled,
    input  wire logic                            i_resolves,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [2:0]                           o_kind,
    output logic [2:0]                           o_slot_a,
    output logic [2:0]                           o_slot_b,
    output logic                                 o_was_resolved,
    output logic signed [scr_pkg::POS_W-1:0]     o_out_x,
    output logic signed [scr_pkg::POS_W-1:0]     o_out_y,
    output logic signed [scr_pkg::POS_W-1:0]     o_out_z,
    output logic                                 o_last
);

    localparam int IW = $clog2(MAX_BODIES);
    localparam int CW = $clog2(MAX_BODIES + 1);
    localparam int BW = $bits(scr_pkg::t_body);

    function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
        if (v > 43'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -43'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic signed [32:0] t;
        t = v[32] ? -v : v;
        return t[31:0];
    endfunction

    // control state
    scr_pkg::t_state r_state, n_state;
    scr_pkg::t_state r_ret, n_ret;
    logic [CW-1:0]   r_i, n_i;
    logic [CW-1:0]   r_j, n_j;
    logic [MAX_BODIES-1:0] r_present, n_present;
    logic [scr_pkg::CFG_W-1:0] r_slots, n_slots;
    logic [2:0]      r_mcnt, n_mcnt;
    logic [1:0]      r_axis, n_axis;
    logic            r_ov, n_ov;

    // datapath
    scr_pkg::t_body     r_ra, n_ra, r_rb, n_rb;
    logic signed [32:0] r_dx, n_dx, r_dy, n_dy, r_dz, n_dz;
    logic [65:0]        r_d2, n_d2;
    logic [63:0]        r_r2, n_r2;
    logic [63:0]        r_prod;
    logic [31:0]        r_dist, n_dist;

    // pending result and output register
    scr_pkg::t_kind     r_pk, n_pk, r_ok, n_ok;
    logic [2:0]         r_pa, n_pa, r_pb, n_pb, r_oa, n_oa, r_ob, n_ob;
    logic               r_pr, n_pr, r_or, n_or, r_pl, n_pl, r_ol, n_ol;
    logic signed [31:0] r_px, n_px, r_py, n_py, r_pz, n_pz;
    logic signed [31:0] r_ox, n_ox, r_oy, n_oy, r_oz, n_oz;

    // memory and units
    logic            ram_we, ram_re;
    logic [IW-1:0]   ram_waddr, ram_raddr;
    scr_pkg::t_body  ram_wdata, ram_rdata;
    logic [BW-1:0]   ram_rbits;
    logic [31:0]     mul_a, mul_b;
    logic            sqrt_start, sqrt_done;
    logic [31:0]     sqrt_root;
    logic            div_start, div_done;
    logic [63:0]     div_quo;

    // combinational helpers
    logic [CW-1:0]      n_act;
    logic [IW-1:0]      free_idx;
    logic               free_found;
    logic               slot_bad;
    logic [31:0]        rsum;
    logic [31:0]        overlap;
    logic signed [32:0] d_sel;
    logic signed [31:0] a_sel, b_sel;
    logic [40:0]        q_clip;
    logic signed [42:0] shift;

    assign ram_rdata = scr_pkg::t_body'(ram_rbits);

    scr_ram #(
        .WIDTH (BW),
        .DEPTH (MAX_BODIES)
    ) u_bodies (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rbits)
    );

    scr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_val   (r_d2[63:0]),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    scr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_prod),
        .i_den   ({r_dist, 1'b0}),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_act = (r_slots > scr_pkg::CFG_W'(MAX_BODIES)) ? CW'(MAX_BODIES) : CW'(r_slots);
        free_idx   = '0;
        free_found = 1'b0;
        for (int k = MAX_BODIES - 1; k >= 0; k--) begin
            if (CW'(k) < n_act && !r_present[k]) begin
                free_idx   = IW'(k);
                free_found = 1'b1;
            end
        end
        slot_bad = ({1'b0, i_slot} >= 4'(MAX_BODIES)) || !r_present[i_slot[IW-1:0]];
        rsum     = {1'b0, r_ra.radius} + {1'b0, r_rb.radius};
        overlap  = rsum - r_dist;
        case (r_axis)
            2'd0: begin
                d_sel = r_dx; a_sel = r_ra.x; b_sel = r_rb.x;
            end
            2'd1: begin
                d_sel = r_dy; a_sel = r_ra.y; b_sel = r_rb.y;
            end
            default: begin
                d_sel = r_dz; a_sel = r_ra.z; b_sel = r_rb.z;
            end
        endcase
        q_clip = (div_quo > 64'(scr_pkg::PUSH_MAX)) ? scr_pkg::PUSH_MAX : div_quo[40:0];
        shift  = d_sel[32] ? -$signed({2'b00, q_clip}) : $signed({2'b00, q_clip});
    end

    always_comb begin
        n_state = r_state;   n_ret  = r_ret;
        n_i     = r_i;       n_j    = r_j;
        n_present = r_present;
        n_slots = i_cfg_we ? i_cfg_data : r_slots;
        n_mcnt  = r_mcnt;    n_axis = r_axis;
        n_ra = r_ra;  n_rb = r_rb;
        n_dx = r_dx;  n_dy = r_dy;  n_dz = r_dz;
        n_d2 = r_d2;  n_r2 = r_r2;  n_dist = r_dist;
        n_pk = r_pk;  n_pa = r_pa;  n_pb = r_pb;  n_pr = r_pr;  n_pl = r_pl;
        n_px = r_px;  n_py = r_py;  n_pz = r_pz;
        n_ok = r_ok;  n_oa = r_oa;  n_ob = r_ob;  n_or = r_or;  n_ol = r_ol;
        n_ox = r_ox;  n_oy = r_oy;  n_oz = r_oz;
        n_ov = (r_ov && !i_stall) ? 1'b0 : r_ov;
        ram_we = 1'b0;  ram_re = 1'b0;
        ram_waddr = r_i[IW-1:0];
        ram_raddr = r_i[IW-1:0];
        ram_wdata = r_ra;
        mul_a = '0;  mul_b = '0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;

        case (r_state)
            scr_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_pk = scr_pkg::K_EMPTY;  n_pa = '0;  n_pb = '0;  n_pr = 1'b0;
                    n_px = '0;  n_py = '0;  n_pz = '0;  n_pl = 1'b1;
                    n_ret = scr_pkg::S_IDLE;
                    n_state = scr_pkg::S_EMIT;
                    case (scr_pkg::t_cmd'(i_cmd))
                        scr_pkg::CMD_ADD: begin
                            if (free_found) begin
                                ram_we    = 1'b1;
                                ram_waddr = free_idx;
                                ram_wdata = '{x: i_pos_x, y: i_pos_y, z: i_pos_z,
                                              radius: i_radius, enabled: i_enabled,
                                              resolves: i_resolves};
                                n_present[free_idx] = 1'b1;
                                n_pk = scr_pkg::K_ADDED;
                                n_pa = 3'(free_idx);
                            end else begin
                                n_pk = scr_pkg::K_FULL;
                            end
                        end
                        scr_pkg::CMD_PASS: begin
                            n_i = '0;
                            n_state = scr_pkg::S_I_SCAN;
                        end
                        default: begin
                            n_pa = i_slot;
                            if (slot_bad) begin
                                n_pk = scr_pkg::K_EMPTY;
                            end else if (i_cmd == scr_pkg::CMD_REMOVE) begin
                                n_present[i_slot[IW-1:0]] = 1'b0;
                                n_pk = scr_pkg::K_REMOVED;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = i_slot[IW-1:0];
                                n_state   = scr_pkg::S_RD_WAIT;
                            end
                        end
                    endcase
                end
            end
            scr_pkg::S_RD_WAIT: begin
                n_pk = scr_pkg::K_READ;
                n_px = ram_rdata.x;  n_py = ram_rdata.y;  n_pz = ram_rdata.z;
                n_state = scr_pkg::S_EMIT;
            end
            scr_pkg::S_EMIT: begin
                if (!r_ov || !i_stall) begin
                    n_ov = 1'b1;
                    n_ok = r_pk;  n_oa = r_pa;  n_ob = r_pb;  n_or = r_pr;  n_ol = r_pl;
                    n_ox = r_px;  n_oy = r_py;  n_oz = r_pz;
                    n_state = r_ret;
                end
            end
            scr_pkg::S_I_SCAN: begin
                if (r_i >= n_act) begin
                    n_pk = scr_pkg::K_DONE;  n_pa = '0;  n_pb = '0;  n_pr = 1'b0;
                    n_px = '0;  n_py = '0;  n_pz = '0;  n_pl = 1'b1;
                    n_ret = scr_pkg::S_IDLE;
                    n_state = scr_pkg::S_EMIT;
                end else if (!r_present[r_i[IW-1:0]]) begin
                    n_i = r_i + 1'b1;
                end else begin
                    ram_re = 1'b1;
                    n_state = scr_pkg::S_I_WAIT;
                end
            end
            scr_pkg::S_I_WAIT: begin
                n_ra = ram_rdata;
                if (!ram_rdata.enabled) begin
                    n_i = r_i + 1'b1;
                    n_state = scr_pkg::S_I_SCAN;
                end else begin
                    n_j = '0;
                    n_state = scr_pkg::S_J_SCAN;
                end
            end
            scr_pkg::S_J_SCAN: begin
                if (r_j >= n_act) begin
                    n_i = r_i + 1'b1;
                    n_state = scr_pkg::S_I_SCAN;
                end else if (r_j == r_i || !r_present[r_j[IW-1:0]]) begin
                    n_j = r_j + 1'b1;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_j[IW-1:0];
                    n_state   = scr_pkg::S_J_WAIT;
                end
            end
            scr_pkg::S_J_WAIT: begin
                n_rb = ram_rdata;
                n_dx = 33'(ram_rdata.x) - 33'(r_ra.x);
                n_dy = 33'(ram_rdata.y) - 33'(r_ra.y);
                n_dz = 33'(ram_rdata.z) - 33'(r_ra.z);
                n_d2 = '0;
                n_mcnt = '0;
                n_state = ram_rdata.enabled ? scr_pkg::S_MUL : scr_pkg::S_J_INC;
            end
            scr_pkg::S_J_INC: begin
                n_j = r_j + 1'b1;
                n_state = scr_pkg::S_J_SCAN;
            end
            scr_pkg::S_MUL: begin
                // squares go in one per cycle; the registered product lands in the next cycle
                case (r_mcnt)
                    3'd0: begin mul_a = mag33(r_dx); mul_b = mag33(r_dx); end
                    3'd1: begin mul_a = mag33(r_dy); mul_b = mag33(r_dy); end
                    3'd2: begin mul_a = mag33(r_dz); mul_b = mag33(r_dz); end
                    3'd3: begin mul_a = rsum; mul_b = rsum; end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
                if (r_mcnt >= 3'd1 && r_mcnt <= 3'd3) begin
                    n_d2 = r_d2 + {2'b00, r_prod};
                end
                if (r_mcnt == 3'd4) begin
                    n_r2 = r_prod;
                    n_state = scr_pkg::S_CMP;
                end
                n_mcnt = r_mcnt + 3'd1;
            end
            scr_pkg::S_CMP: begin
                if (r_d2 >= {2'b00, r_r2}) begin
                    n_state = scr_pkg::S_J_INC;
                end else if (!(r_ra.resolves && r_rb.resolves) || r_d2 == '0) begin
                    n_pk = scr_pkg::K_HIT;  n_pa = 3'(r_i);  n_pb = 3'(r_j);
                    n_pr = r_ra.resolves && r_rb.resolves;
                    n_px = '0;  n_py = '0;  n_pz = '0;  n_pl = 1'b0;
                    n_ret = scr_pkg::S_J_INC;
                    n_state = scr_pkg::S_EMIT;
                end else begin
                    sqrt_start = 1'b1;
                    n_state = scr_pkg::S_SQRT;
                end
            end
            scr_pkg::S_SQRT: begin
                if (sqrt_done) begin
                    n_dist = sqrt_root;
                    n_axis = '0;
                    n_state = scr_pkg::S_PMUL;
                end
            end
            scr_pkg::S_PMUL: begin
                mul_a = mag33(d_sel);
                mul_b = overlap;
                n_state = scr_pkg::S_PDIV;
            end
            scr_pkg::S_PDIV: begin
                div_start = 1'b1;
                n_state = scr_pkg::S_DIV;
            end
            scr_pkg::S_DIV: begin
                if (div_done) begin
                    case (r_axis)
                        2'd0: begin
                            n_ra.x = sat32(43'(a_sel) - shift);
                            n_rb.x = sat32(43'(b_sel) + shift);
                        end
                        2'd1: begin
                            n_ra.y = sat32(43'(a_sel) - shift);
                            n_rb.y = sat32(43'(b_sel) + shift);
                        end
                        default: begin
                            n_ra.z = sat32(43'(a_sel) - shift);
                            n_rb.z = sat32(43'(b_sel) + shift);
                        end
                    endcase
                    if (r_axis == 2'd2) begin
                        n_state = scr_pkg::S_WB_B;
                    end else begin
                        n_axis = r_axis + 2'd1;
                        n_state = scr_pkg::S_PMUL;
                    end
                end
            end
            scr_pkg::S_WB_B: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[IW-1:0];
                ram_wdata = r_rb;
                n_state   = scr_pkg::S_WB_A;
            end
            scr_pkg::S_WB_A: begin
                ram_we = 1'b1;
                n_pk = scr_pkg::K_HIT;  n_pa = 3'(r_i);  n_pb = 3'(r_j);  n_pr = 1'b1;
                n_px = '0;  n_py = '0;  n_pz = '0;  n_pl = 1'b0;
                n_ret = scr_pkg::S_J_INC;
                n_state = scr_pkg::S_EMIT;
            end
            default: begin
                n_state = scr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= scr_pkg::S_IDLE;
            r_ret     <= scr_pkg::S_IDLE;
            r_i       <= '0;
            r_j       <= '0;
            r_present <= '0;
            r_slots   <= scr_pkg::CFG_W'(MAX_BODIES);
            r_mcnt    <= '0;
            r_axis    <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_i       <= n_i;
            r_j       <= n_j;
            r_present <= n_present;
            r_slots   <= n_slots;
            r_mcnt    <= n_mcnt;
            r_axis    <= n_axis;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ra   <= n_ra;    r_rb <= n_rb;
        r_dx   <= n_dx;    r_dy <= n_dy;    r_dz <= n_dz;
        r_d2   <= n_d2;    r_r2 <= n_r2;    r_dist <= n_dist;
        r_prod <= 64'(mul_a) * 64'(mul_b);
        r_pk <= n_pk;  r_pa <= n_pa;  r_pb <= n_pb;  r_pr <= n_pr;  r_pl <= n_pl;
        r_px <= n_px;  r_py <= n_py;  r_pz <= n_pz;
        r_ok <= n_ok;  r_oa <= n_oa;  r_ob <= n_ob;  r_or <= n_or;  r_ol <= n_ol;
        r_ox <= n_ox;  r_oy <= n_oy;  r_oz <= n_oz;
    end

    assign o_stall        = (r_state != scr_pkg::S_IDLE);
    assign o_valid        = r_ov;
    assign o_kind         = r_ok;
    assign o_slot_a       = r_oa;
    assign o_slot_b       = r_ob;
    assign o_was_resolved = r_or;
    assign o_out_x        = r_ox;
    assign o_out_y        = r_oy;
    assign o_out_z        = r_oz;
    assign o_last         = r_ol;

    // the body memory never sees a read and a write in the same cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(ram_we && ram_re))
        else $error("body memory read and write collide");

    // the outer index stays inside the searched slots while the inner loop runs
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scr_pkg::S_J_SCAN) |-> (r_i < n_act))
        else $error("outer index out of range in inner loop");

    // a pass-done beat always closes its command
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == scr_pkg::K_DONE) |-> o_last)
        else $error("pass done without last");

    // a hit never names the same body twice
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == scr_pkg::K_HIT) |-> (o_slot_a != o_slot_b))
        else $error("self-pair reported");

    // a divide only starts after a nonzero square root
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_dist != '0))
        else $error("push divide by zero distance");

endmodule

`default_nettype wire

// ===== tb/sphere_collision_resolver_tb.sv =====
// Self-checking testbench for sphere_collision_resolver: directed table plus random
// command mix, checked against an in-bench collision predictor. Depends on scr_pkg
// and the resolver RTL.
`timescale 1ns / 1ps

module sphere_collision_resolver_tb;
    import scr_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 600;

    typedef struct packed {
        t_cmd        cmd;
        logic [2:0]  slot;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [30:0] r;
        logic        en;
        logic        res;
    } t_item;

    typedef struct packed {
        t_item      it;
        logic       typed;
        t_kind      kind;
        logic [2:0] sa;
    } t_row;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  a;
        logic [2:0]  b;
        logic        resolved;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_cmd;
    logic [2:0]  i_slot;
    logic [31:0] i_pos_x;
    logic [31:0] i_pos_y;
    logic [31:0] i_pos_z;
    logic [30:0] i_radius;
    logic        i_enabled;
    logic        i_resolves;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_kind;
    logic [2:0]  o_slot_a;
    logic [2:0]  o_slot_b;
    logic        o_was_resolved;
    logic [31:0] o_out_x;
    logic [31:0] o_out_y;
    logic [31:0] o_out_z;
    logic        o_last;

    sphere_collision_resolver uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(i_cmd), .i_slot(i_slot),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_radius(i_radius), .i_enabled(i_enabled), .i_resolves(i_resolves),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_kind(o_kind), .o_slot_a(o_slot_a), .o_slot_b(o_slot_b),
        .o_was_resolved(o_was_resolved),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_z(o_out_z),
        .o_last(o_last)
    );

    // predictor state
    longint          body_px [8];
    longint          body_py [8];
    longint          body_pz [8];
    longint unsigned body_rad[8];
    bit              body_in [8];
    bit              body_on [8];
    bit              body_push[8];
    int unsigned     slots_cfg;

    t_result pending_results[$];
    int      errors;
    int      burst_left;
    bit      hold_req;
    int      hold_cnt;
    int      stall_mode;
    int      mode_cnt;
    int      idle_cycles;
    t_row    dir_tab[22];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned mag64(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned bt;
        r  = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= r + bt) begin
                v = v - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    function automatic void push_apart(ref longint pa, ref longint pb, input longint d,
                                       input longint unsigned ov, input longint unsigned span);
        longint unsigned q;
        longint s;
        q = (mag64(d) * ov) / (64'd2 * span);
        if (q > (64'd1 << 40)) q = 64'd1 << 40;
        s  = (d < 0) ? -longint'(q) : longint'(q);
        pa = sat32(pa - s);
        pb = sat32(pb + s);
    endfunction

    // returns hit; resolved reports whether both bodies resolve (coincident centers are not pushed)
    function automatic bit pair_hit(int i, int j, output bit resolved);
        longint dx, dy, dz;
        longint unsigned sx, sy, sz, lo, rsum, r2, span;
        int hi;
        dx = body_px[j] - body_px[i];
        dy = body_py[j] - body_py[i];
        dz = body_pz[j] - body_pz[i];
        sx = mag64(dx) * mag64(dx);
        sy = mag64(dy) * mag64(dy);
        sz = mag64(dz) * mag64(dz);
        hi = 0;
        lo = sx + sy;
        if (lo < sy) hi++;
        lo = lo + sz;
        if (lo < sz) hi++;
        rsum = body_rad[i] + body_rad[j];
        r2   = rsum * rsum;
        resolved = 1'b0;
        if (hi != 0 || lo >= r2) return 1'b0;
        if (!(body_push[i] && body_push[j])) return 1'b1;
        resolved = 1'b1;
        if (lo == 0) return 1'b1;   // coincident centers: no push
        span = isqrt(lo);
        push_apart(body_px[i], body_px[j], dx, rsum - span, span);
        push_apart(body_py[i], body_py[j], dy, rsum - span, span);
        push_apart(body_pz[i], body_pz[j], dz, rsum - span, span);
        return 1'b1;
    endfunction

    function automatic void add_result(t_kind k, int a, int b, bit rs,
                                       longint x, longint y, longint z);
        t_result e;
        e = '{kind: k, a: a[2:0], b: b[2:0], resolved: rs,
              x: x[31:0], y: y[31:0], z: z[31:0], last: 1'b0};
        pending_results.push_back(e);
    endfunction

    function automatic void predict_collisions(t_item it);
        int n, i, j;
        bit rs;
        t_result e;
        n = (slots_cfg > 8) ? 8 : slots_cfg;
        case (it.cmd)
            CMD_ADD: begin
                for (i = 0; i < n; i++) if (!body_in[i]) break;
                if (i < n) begin
                    body_px[i]   = longint'($signed(it.x));
                    body_py[i]   = longint'($signed(it.y));
                    body_pz[i]   = longint'($signed(it.z));
                    body_rad[i]  = it.r;
                    body_on[i]   = it.en;
                    body_push[i] = it.res;
                    body_in[i]   = 1'b1;
                    add_result(K_ADDED, i, 0, 0, 0, 0, 0);
                end else begin
                    add_result(K_FULL, 0, 0, 0, 0, 0, 0);
                end
            end
            CMD_REMOVE, CMD_READ: begin
                if (!body_in[it.slot]) begin
                    add_result(K_EMPTY, it.slot, 0, 0, 0, 0, 0);
                end else if (it.cmd == CMD_REMOVE) begin
                    body_in[it.slot] = 1'b0;
                    add_result(K_REMOVED, it.slot, 0, 0, 0, 0, 0);
                end else begin
                    add_result(K_READ, it.slot, 0, 0, body_px[it.slot],
                               body_py[it.slot], body_pz[it.slot]);
                end
            end
            default: begin
                for (i = 0; i < n; i++) begin
                    if (!body_in[i] || !body_on[i]) continue;
                    for (j = 0; j < n; j++) begin
                        if (j == i || !body_in[j] || !body_on[j]) continue;
                        if (pair_hit(i, j, rs)) add_result(K_HIT, i, j, rs, 0, 0, 0);
                    end
                end
                add_result(K_DONE, 0, 0, 0, 0, 0, 0);
            end
        endcase
        e = pending_results.pop_back();
        e.last = 1'b1;
        pending_results.push_back(e);
    endfunction

    // hold valid through a burst, drop it only for a gap
    task automatic send_beat(t_item it, bit typed = 1'b0, t_kind kind = K_DONE,
                             logic [2:0] sa = 3'd0);
        t_result e;
        i_valid    <= 1'b1;
        i_cmd      <= it.cmd;
        i_slot     <= it.slot;
        i_pos_x    <= it.x;
        i_pos_y    <= it.y;
        i_pos_z    <= it.z;
        i_radius   <= it.r;
        i_enabled  <= it.en;
        i_resolves <= it.res;
        do @(posedge i_clk); while (o_stall);
        predict_collisions(it);
        // a typed row replaces the predicted single result before it can come out
        if (typed) begin
            void'(pending_results.pop_back());
            add_result(kind, sa, 0, 0, 0, 0, 0);
            e = pending_results.pop_back();
            e.last = 1'b1;
            pending_results.push_back(e);
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 9);
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_slots(logic [3:0] v);
        i_valid <= 1'b0;
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        slots_cfg  = v;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_pos();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endfunction

    function automatic t_item rand_item();
        t_item it;
        int pick;
        pick   = $urandom_range(0, 99);
        it.cmd = (pick < 40) ? CMD_ADD : (pick < 60) ? CMD_REMOVE :
                 (pick < 75) ? CMD_PASS : CMD_READ;
        it.slot = $urandom_range(0, 7);
        it.x    = rand_pos();
        it.y    = rand_pos();
        it.z    = rand_pos();
        case ($urandom_range(0, 9))
            0:       it.r = $urandom;
            1:       it.r = '0;
            default: it.r = $urandom_range(32'h0001_0000, 32'h0003_0000);
        endcase
        it.en  = ($urandom_range(0, 5) != 0);
        it.res = ($urandom_range(0, 3) != 0);
        return it;
    endfunction

    // output side: check beats, stall on a drifting pattern, long hold on request
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected beat kind=%0d a=%0d", $time, o_kind, o_slot_a);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_kind !== e.kind || o_slot_a !== e.a || o_slot_b !== e.b ||
                    o_was_resolved !== e.resolved || o_out_x !== e.x ||
                    o_out_y !== e.y || o_out_z !== e.z || o_last !== e.last) begin
                    $display("%0t: mismatch exp k=%0d a=%0d b=%0d r=%0d x=%h y=%h z=%h l=%0d",
                             $time, e.kind, e.a, e.b, e.resolved, e.x, e.y, e.z, e.last);
                    $display("%0t:          got k=%0d a=%0d b=%0d r=%0d x=%h y=%h z=%h l=%0d",
                             $time, o_kind, o_slot_a, o_slot_b, o_was_resolved,
                             o_out_x, o_out_y, o_out_z, o_last);
                    errors++;
                end
            end
        end
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = HOLD_CYCLES;
        end
        if (mode_cnt == 0) begin
            mode_cnt   = $urandom_range(50, 300);
            stall_mode = $urandom_range(0, 2);
        end else begin
            mode_cnt--;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [3:0] cfg_list[6];
        int k, p;
        errors = 0; burst_left = 0; hold_req = 0; hold_cnt = 0;
        stall_mode = 0; mode_cnt = 0; idle_cycles = 0;
        for (k = 0; k < 8; k++) body_in[k] = 1'b0;
        slots_cfg  = 8;
        i_rst_n    <= 1'b0; i_cfg_we <= 1'b0; i_cfg_data <= '0;
        i_valid    <= 1'b0; i_cmd <= CMD_ADD; i_slot <= '0;
        i_pos_x    <= '0; i_pos_y <= '0; i_pos_z <= '0; i_radius <= '0;
        i_enabled  <= 1'b0; i_resolves <= 1'b0;

        dir_tab = '{
            '{'{CMD_READ,   3'd0, 32'h0, 32'h0, 32'h0, 31'h0, 1'b0, 1'b0}, 1'b1, K_EMPTY, 3'd0},
            '{'{CMD_REMOVE, 3'd7, 32'h0, 32'h0, 32'h0, 31'h0, 1'b0, 1'b0}, 1'b1, K_EMPTY, 3'd7},
            '{'{CMD_PASS,   3'd0, 32'h0, 32'h0, 32'h0, 31'h0, 1'b0, 1'b0}, 1'b1, K_DONE,  3'd0},
            // two coincident resolving bodies, then one overlapping both
            '{'{CMD_ADD, 3'd0, 32'h0, 32'h0, 32'h0, 31'h1_0000, 1'b1, 1'b1}, 1'b1, K_ADDED, 3'd0},
            '{'{CMD_ADD, 3'd0, 32'h0, 32'h0, 32'h0, 31'h1_0000, 1'b1, 1'b1}, 1'b1, K_ADDED, 3'd1},
            '{'{CMD_ADD, 3'd7, 32'h1_0000, 32'h0, 32'h0, 31'h1_0000, 1'b1, 1'b1},
              1'b1, K_ADDED, 3'd2},
            '{'{CMD_ADD, 3'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff,
                1'b1, 1'b1}, 1'b1, K_ADDED, 3'd3},
            '{'{CMD_ADD, 3'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff,
                1'b1, 1'b1}, 1'b1, K_ADDED, 3'd4},
            '{'{CMD_ADD, 3'd0, 32'h0, 32'h8000, 32'h0, 31'h1_0000, 1'b1, 1'b0},
              1'b1, K_ADDED, 3'd5},
            '{'{CMD_ADD, 3'd0, 32'h0, 32'h0, 32'h0, 31'h1_0000, 1'b0, 1'b1}, 1'b1, K_ADDED, 3'd6},
            '{'{CMD_ADD, 3'd0, 32'h3_0000, 32'hffff_0000, 32'h0, 31'h2_0000, 1'b1, 1'b1},
              1'b1, K_ADDED, 3'd7},
            '{'{CMD_ADD, 3'd0, 32'h5, 32'h5, 32'h5, 31'h5, 1'b1, 1'b1}, 1'b1, K_FULL, 3'd0},
            '{'{CMD_PASS, 3'd0, 32'h0, 32'h0, 32'h0, 31'h0, 1'b0, 1'b0}, 1'b0, K_DONE, 3'd0},
            '{'{CMD_READ, 3'd0, 32'h0, 32'h0, 32'h0, 31'h0, 1'b0, 1'b0}, 1'b0, K_READ, 3'd0},
            '{'{CMD_READ, 3'd2, 32'h0, 32'h0, 32'h0, 31'h0, 1'b0, 1'b0}, 1'b0, K_READ, 3'd0},
            '{'{CMD_READ, 3'd3, 32'h0, 32'h0, 32'h0, 31'h0, 1'b0, 1'b0}, 1'b0, K_READ, 3'd0},
            '{'{CMD_READ, 3'd4, 32'h0, 32'h0, 32'h0, 31'h0, 1'b0, 1'b0}, 1'b0, K_READ, 3'd0},
            '{'{CMD_REMOVE, 3'd3, 32'h0, 32'h0, 32'h0, 31'h0, 1'b0, 1'b0}, 1'b1, K_REMOVED, 3'd3},
            '{'{CMD_READ,   3'd3, 32'h0, 32'h0, 32'h0, 31'h0, 1'b0, 1'b0}, 1'b1, K_EMPTY, 3'd3},
            '{'{CMD_ADD, 3'd0, 32'h1234_5678, 32'hedcb_a987, 32'h0, 31'h5555_5555, 1'b1, 1'b0},
              1'b1, K_ADDED, 3'd3},
            '{'{CMD_PASS, 3'd0, 32'h0, 32'h0, 32'h0, 31'h0, 1'b0, 1'b0}, 1'b0, K_DONE, 3'd0},
            '{'{CMD_READ, 3'd7, 32'h0, 32'h0, 32'h0, 31'h0, 1'b0, 1'b0}, 1'b0, K_READ, 3'd0}
        };
        cfg_list = '{4'd3, 4'd0, 4'd15, 4'd2, 4'd8, 4'd6};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < 22; k++) begin
            send_beat(dir_tab[k].it, dir_tab[k].typed, dir_tab[k].kind, dir_tab[k].sa);
        end

        for (p = 0; p < 6; p++) begin
            write_slots(cfg_list[p]);
            if (p == 0) hold_req = 1'b1;
            for (k = 0; k < 26; k++) send_beat(rand_item());
        end
        i_valid <= 1'b0;

        wait_idle();
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
